// File: rtl/qebd_pkg.sv
// Shared types, pin map and constants for the quadrature encoder and button decoder.
package qebd_pkg;

    localparam int NUM_ENCODERS    = 4;
    localparam int NUM_AUX_BUTTONS = 4;
    localparam int COUNT_WIDTH     = 32;

    localparam int MAX_ENCODERS = 4;
    localparam int NUM_BUTTONS  = 8;
    localparam int POS_WIDTH    = 32;
    localparam int PIN_WIDTH    = 16;
    localparam int PIN_IDX_W    = 4;
    localparam int TIME_WIDTH   = 32;
    localparam int DEB_WIDTH    = 16;
    localparam int IDX_WIDTH    = 3;
    localparam int CMD_WIDTH    = 2;

    localparam logic [DEB_WIDTH-1:0] DEBOUNCE_RESET = DEB_WIDTH'(20);

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_SNAPSHOT = 2'd0,
        CMD_TAKE     = 2'd1,
        CMD_ZERO     = 2'd2,
        CMD_PRIME    = 2'd3
    } cmd_t;

    // per-channel control: word is being processed this cycle, its command,
    // and whether target_index selects this channel
    typedef struct packed {
        logic fire;
        cmd_t cmd;
        logic hit;
    } chan_ctrl_t;

    typedef logic [PIN_IDX_W-1:0] pin_idx_t;

    localparam pin_idx_t PIN_A   [MAX_ENCODERS] = '{4'd4, 4'd8, 4'd11, 4'd7};
    localparam pin_idx_t PIN_B   [MAX_ENCODERS] = '{4'd3, 4'd9, 4'd12, 4'd6};
    localparam pin_idx_t PIN_SW  [MAX_ENCODERS] = '{4'd2, 4'd10, 4'd13, 4'd5};
    localparam pin_idx_t PIN_AUX [MAX_ENCODERS] = '{4'd0, 4'd1, 4'd14, 4'd15};

    // 4x4 quadrature transition table, phase = {B, A}; jumps give 0
    function automatic logic signed [1:0] quad_step(input logic [1:0] prev_ph,
                                                     input logic [1:0] cur_ph);
        logic signed [1:0] s;
        unique case ({prev_ph, cur_ph})
            4'b0001, 4'b0111, 4'b1000, 4'b1110: s = 2'sd1;
            4'b0010, 4'b0100, 4'b1011, 4'b1101: s = -2'sd1;
            default:                            s = 2'sd0;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/qebd_enc_chan.sv
// One quadrature channel: phase register and wrapping position counter.
module qebd_enc_chan (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  qebd_pkg::chan_ctrl_t                      ctrl,
    input  logic [1:0]                                phase_in,
    output logic signed [qebd_pkg::COUNT_WIDTH-1:0]   count_next
);

    logic [1:0]                                phase_reg;
    logic [1:0]                                phase_next;
    logic signed [qebd_pkg::COUNT_WIDTH-1:0]   count_reg;
    logic signed [1:0]                         step;

    assign step = qebd_pkg::quad_step(phase_reg, phase_in);

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (ctrl.fire) begin
            unique case (ctrl.cmd)
                qebd_pkg::CMD_SNAPSHOT: begin
                    phase_next = phase_in;
                    count_next = count_reg + qebd_pkg::COUNT_WIDTH'(step);
                end
                qebd_pkg::CMD_TAKE: begin
                end
                qebd_pkg::CMD_ZERO: begin
                    if (ctrl.hit) count_next = '0;
                end
                qebd_pkg::CMD_PRIME: begin
                    phase_next = phase_in;
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/qebd_btn_chan.sv
// One active-low button: lockout debounce, accepted level and sticky press flag.
module qebd_btn_chan (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  qebd_pkg::chan_ctrl_t                ctrl,
    input  logic                                pressed,
    input  logic [qebd_pkg::TIME_WIDTH-1:0]     now,
    input  logic [qebd_pkg::DEB_WIDTH-1:0]      lockout_ms,
    output logic                                flag_next,
    output logic                                taken
);

    logic                                level_reg;
    logic                                level_next;
    logic [qebd_pkg::TIME_WIDTH-1:0]     last_reg;
    logic [qebd_pkg::TIME_WIDTH-1:0]     last_next;
    logic                                flag_reg;
    logic [qebd_pkg::TIME_WIDTH-1:0]     elapsed;
    logic                                lockout_done;

    // wrapping difference, so timestamp rollover is harmless
    assign elapsed      = now - last_reg;
    assign lockout_done = elapsed >= qebd_pkg::TIME_WIDTH'(lockout_ms);

    always_comb begin
        level_next = level_reg;
        last_next  = last_reg;
        flag_next  = flag_reg;
        taken      = 1'b0;
        if (ctrl.fire) begin
            unique case (ctrl.cmd)
                qebd_pkg::CMD_SNAPSHOT: begin
                    if ((pressed != level_reg) && lockout_done) begin
                        level_next = pressed;
                        last_next  = now;
                        if (pressed) flag_next = 1'b1;
                    end
                end
                qebd_pkg::CMD_TAKE: begin
                    if (ctrl.hit) begin
                        taken     = flag_reg;
                        flag_next = 1'b0;
                    end
                end
                qebd_pkg::CMD_ZERO: begin
                end
                qebd_pkg::CMD_PRIME: begin
                    level_next = pressed;
                    last_next  = '0;
                    flag_next  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 1'b0;
            last_reg  <= '0;
            flag_reg  <= 1'b0;
        end else begin
            level_reg <= level_next;
            last_reg  <= last_next;
            flag_reg  <= flag_next;
        end
    end

endmodule

// File: rtl/quad_encoder_button_decoder.sv
// Top level: quadrature encoder and debounced button decoder with stream ports.
// Path: an accepted word waits in the input register, then one pass of per-channel
// logic writes its result into the result register, which drives m_*.
// Throughput: one word per cycle; s_ready drops only while both registers hold words
// and m_ready is low; the channel update and 32-bit lockout compare set the path.
// Reset (aresetn, synchronous): all channel state and both valid flags clear, lockout 20 ms.
module quad_encoder_button_decoder (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    input  logic                                    cfg_wr_en,
    input  logic [qebd_pkg::DEB_WIDTH-1:0]          cfg_wr_data,

    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [qebd_pkg::CMD_WIDTH-1:0]          s_cmd,
    input  logic [qebd_pkg::PIN_WIDTH-1:0]          s_pin_snapshot,
    input  logic [qebd_pkg::TIME_WIDTH-1:0]         s_time_ms,
    input  logic [qebd_pkg::IDX_WIDTH-1:0]          s_target_index,

    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [qebd_pkg::POS_WIDTH-1:0]   m_position_enc0,
    output logic signed [qebd_pkg::POS_WIDTH-1:0]   m_position_enc1,
    output logic signed [qebd_pkg::POS_WIDTH-1:0]   m_position_enc2,
    output logic signed [qebd_pkg::POS_WIDTH-1:0]   m_position_enc3,
    output logic [qebd_pkg::NUM_BUTTONS-1:0]        m_pending_presses,
    output logic                                    m_taken_press
);

    // debounce register
    logic [qebd_pkg::DEB_WIDTH-1:0]       debounce_reg;

    // input register
    logic                                 in_valid_reg;
    qebd_pkg::cmd_t                       in_cmd_reg;
    logic [qebd_pkg::PIN_WIDTH-1:0]       in_pins_reg;
    logic [qebd_pkg::TIME_WIDTH-1:0]      in_time_reg;
    logic [qebd_pkg::IDX_WIDTH-1:0]       in_tgt_reg;

    // result register
    logic                                 out_valid_reg;
    logic signed [qebd_pkg::POS_WIDTH-1:0] out_pos_reg [qebd_pkg::MAX_ENCODERS];
    logic [qebd_pkg::NUM_BUTTONS-1:0]     out_pend_reg;
    logic                                 out_taken_reg;

    logic                                 advance;
    logic                                 s_accept;
    logic signed [qebd_pkg::POS_WIDTH-1:0] pos_next [qebd_pkg::MAX_ENCODERS];
    logic [qebd_pkg::NUM_BUTTONS-1:0]     pend_next;
    logic [qebd_pkg::NUM_BUTTONS-1:0]     taken_vec;

    // the held word moves on when the result slot is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= qebd_pkg::DEBOUNCE_RESET;
        end else if (cfg_wr_en) begin
            debounce_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg  <= qebd_pkg::cmd_t'(s_cmd);
            in_pins_reg <= s_pin_snapshot;
            in_time_reg <= s_time_ms;
            in_tgt_reg  <= s_target_index;
        end
    end

    // encoder channels; absent ones read zero
    genvar e;
    generate
        for (e = 0; e < qebd_pkg::MAX_ENCODERS; e++) begin : g_enc
            if (e < qebd_pkg::NUM_ENCODERS) begin : g_on
                qebd_pkg::chan_ctrl_t                      ctrl;
                logic [1:0]                                phase;
                logic signed [qebd_pkg::COUNT_WIDTH-1:0]   cnt;

                assign ctrl.fire = advance;
                assign ctrl.cmd  = in_cmd_reg;
                assign ctrl.hit  = (in_tgt_reg == qebd_pkg::IDX_WIDTH'(e));
                assign phase     = {in_pins_reg[qebd_pkg::PIN_B[e]],
                                    in_pins_reg[qebd_pkg::PIN_A[e]]};

                qebd_enc_chan u_enc (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .ctrl       (ctrl),
                    .phase_in   (phase),
                    .count_next (cnt)
                );

                // sign-extend from the counter width
                assign pos_next[e] = qebd_pkg::POS_WIDTH'(cnt);
            end else begin : g_off
                assign pos_next[e] = '0;
            end
        end
    endgenerate

    // buttons: 0-3 encoder switches, 4-7 aux; all active low
    genvar b;
    generate
        for (b = 0; b < qebd_pkg::NUM_BUTTONS; b++) begin : g_btn
            localparam bit IS_SW = (b < qebd_pkg::MAX_ENCODERS);
            localparam int SUB   = IS_SW ? b : b - qebd_pkg::MAX_ENCODERS;
            localparam bit ON    = IS_SW ? (SUB < qebd_pkg::NUM_ENCODERS)
                                         : (SUB < qebd_pkg::NUM_AUX_BUTTONS);
            if (ON) begin : g_on
                qebd_pkg::chan_ctrl_t   ctrl;
                logic                   pressed;

                assign ctrl.fire = advance;
                assign ctrl.cmd  = in_cmd_reg;
                assign ctrl.hit  = (in_tgt_reg == qebd_pkg::IDX_WIDTH'(b));
                assign pressed   = IS_SW ? !in_pins_reg[qebd_pkg::PIN_SW[SUB]]
                                         : !in_pins_reg[qebd_pkg::PIN_AUX[SUB]];

                qebd_btn_chan u_btn (
                    .aclk        (aclk),
                    .aresetn     (aresetn),
                    .ctrl        (ctrl),
                    .pressed     (pressed),
                    .now         (in_time_reg),
                    .lockout_ms  (debounce_reg),
                    .flag_next   (pend_next[b]),
                    .taken       (taken_vec[b])
                );
            end else begin : g_off
                assign pend_next[b] = 1'b0;
                assign taken_vec[b] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_pos_reg   <= pos_next;
            out_pend_reg  <= pend_next;
            out_taken_reg <= |taken_vec;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_position_enc0   = out_pos_reg[0];
    assign m_position_enc1   = out_pos_reg[1];
    assign m_position_enc2   = out_pos_reg[2];
    assign m_position_enc3   = out_pos_reg[3];
    assign m_pending_presses = out_pend_reg;
    assign m_taken_press     = out_taken_reg;

`ifndef SYNTHESIS
    // back-pressure only when both slots are full and the sink stalls
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("s_ready low without a full stalled pipeline");

    // a take always leaves the targeted flag cleared
    a_take_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg == qebd_pkg::CMD_TAKE)
        |=> !m_pending_presses[$past(in_tgt_reg)])
        else $error("take word left its press flag set");

    // prime clears every count and flag
    a_prime_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg == qebd_pkg::CMD_PRIME)
        |=> (m_pending_presses == '0 && m_position_enc0 == '0 &&
             m_position_enc1 == '0 && m_position_enc2 == '0 &&
             m_position_enc3 == '0 && !m_taken_press))
        else $error("prime word left state behind");

    // a taken press only comes out of a take word
    a_taken_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg != qebd_pkg::CMD_TAKE) |=> !m_taken_press)
        else $error("taken_press set by a non-take word");
`endif

endmodule
